// ===== hw/rtl/mpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants for the mesh packet framer with CRC-16 trailer.
// ----------------------------------------------------------------------------
package mpf_pkg;

   localparam int NODE_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int CRC_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCAL_NODE     = 2'd0,
      CSR_CHANNEL_NUMBER = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      STEP_SRC0    = 4'd0,
      STEP_SRC1    = 4'd1,
      STEP_SRC2    = 4'd2,
      STEP_SRC3    = 4'd3,
      STEP_DST0    = 4'd4,
      STEP_DST1    = 4'd5,
      STEP_DST2    = 4'd6,
      STEP_DST3    = 4'd7,
      STEP_CHAN    = 4'd8,
      STEP_PAYLOAD = 4'd9,
      STEP_CRC_LO  = 4'd10,
      STEP_CRC_HI  = 4'd11
   } step_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_present;
      logic              last_item;
      logic [NODE_W-1:0] dest_node;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_end;
   } result_type;

endpackage

// ===== hw/rtl/mpf_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_stream_if
// Valid/ready stream channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface mpf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mesh_packet_framer_crc16_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_packet_framer_crc16_unit
// Frames payload bytes into mesh packets with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries payload items; rsp_chan carries framed bytes, one per
//  transfer. csr_* writes local_node (index 0) and channel_number (index 1);
//  write only while no packet is in flight.
//  The first item of a packet produces a 9-byte header (local node and
//  destination big-endian, then channel), then its payload byte if present.
//  An item marked last adds the CRC, low byte first; frame_end flags the
//  high byte. Items with neither a byte nor the last mark are dropped.
//  The first byte of an item passes through the item and output registers.
//  Throughput: one output byte per cycle while rsp_chan is ready; an item
//  emits 9 bytes for a header, 1 for a payload byte and 2 for the CRC. The byte
//  sequencer emits one byte per cycle and holds req_chan until the current
//  item's last byte leaves; the next item is taken in that same cycle.
//  Reset clears the item and output valid flags, closes any open packet and
//  sets the running CRC to 0xFFFF; local_node and channel_number return to zero.
//  When rsp_chan stalls, the output register holds and the sequencer waits.
// ----------------------------------------------------------------------------
module mesh_packet_framer_crc16_unit (
   input  logic                                clock,
   input  logic                                reset,
   mpf_stream_if.sink                          req_chan,
   mpf_stream_if.source                        rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [mpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mpf_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   logic [mpf_pkg::NODE_W-1:0] local_node_ff;
   logic [mpf_pkg::BYTE_W-1:0] channel_ff;

   mpf_pkg::item_type          item_ff;
   logic                       item_valid_ff, item_valid_in;
   mpf_pkg::step_type          step_ff, step_in, step_next, step_start;
   logic                       inside_ff, inside_in;
   logic [mpf_pkg::CRC_W-1:0]  crc_ff, crc_in, crc_fed;

   mpf_pkg::result_type        rsp_ff;
   logic                       rsp_valid_ff;

   logic                       out_free, emit, item_done, accept, load;
   logic [mpf_pkg::BYTE_W-1:0] cur_byte;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         local_node_ff <= '0;
         channel_ff    <= '0;
      end else if (csr_wr_en) begin
         case (mpf_pkg::csr_index_type'(csr_index))
            mpf_pkg::CSR_LOCAL_NODE:     local_node_ff <= csr_wr_data;
            mpf_pkg::CSR_CHANNEL_NUMBER: channel_ff <= csr_wr_data[mpf_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // byte select
   always_comb begin
      case (step_ff)
         mpf_pkg::STEP_SRC0:    cur_byte = local_node_ff[31:24];
         mpf_pkg::STEP_SRC1:    cur_byte = local_node_ff[23:16];
         mpf_pkg::STEP_SRC2:    cur_byte = local_node_ff[15:8];
         mpf_pkg::STEP_SRC3:    cur_byte = local_node_ff[7:0];
         mpf_pkg::STEP_DST0:    cur_byte = item_ff.dest_node[31:24];
         mpf_pkg::STEP_DST1:    cur_byte = item_ff.dest_node[23:16];
         mpf_pkg::STEP_DST2:    cur_byte = item_ff.dest_node[15:8];
         mpf_pkg::STEP_DST3:    cur_byte = item_ff.dest_node[7:0];
         mpf_pkg::STEP_CHAN:    cur_byte = channel_ff;
         mpf_pkg::STEP_PAYLOAD: cur_byte = item_ff.payload_byte;
         mpf_pkg::STEP_CRC_LO:  cur_byte = crc_ff[7:0];
         mpf_pkg::STEP_CRC_HI:  cur_byte = crc_ff[15:8];
         default:               cur_byte = '0;
      endcase
   end

   mpf_crc16_step u_crc (
      .crc_cur   (crc_ff),
      .data_byte (cur_byte),
      .crc_nxt   (crc_fed)
   );

   // sequencing
   always_comb begin
      item_done = 1'b0;
      step_next = step_ff;
      case (step_ff)
         mpf_pkg::STEP_CHAN: begin
            if (item_ff.byte_present) begin
               step_next = mpf_pkg::STEP_PAYLOAD;
            end else if (item_ff.last_item) begin
               step_next = mpf_pkg::STEP_CRC_LO;
            end else begin
               item_done = 1'b1;
            end
         end
         mpf_pkg::STEP_PAYLOAD: begin
            if (item_ff.last_item) begin
               step_next = mpf_pkg::STEP_CRC_LO;
            end else begin
               item_done = 1'b1;
            end
         end
         mpf_pkg::STEP_CRC_LO: step_next = mpf_pkg::STEP_CRC_HI;
         mpf_pkg::STEP_CRC_HI: item_done = 1'b1;
         default:              step_next = mpf_pkg::step_type'(step_ff + 4'd1);
      endcase
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign emit           = item_valid_ff && out_free;
   assign req_chan.ready = !item_valid_ff || (emit && item_done);
   assign accept         = req_chan.valid && req_chan.ready;
   assign load           = accept && (req_chan.payload.byte_present ||
                                      req_chan.payload.last_item);

   always_comb begin
      inside_in = inside_ff;
      crc_in    = crc_ff;
      if (emit) begin
         if (step_ff == mpf_pkg::STEP_CRC_HI) begin
            inside_in = 1'b0;
            crc_in    = mpf_pkg::CRC_INIT;
         end else if (step_ff != mpf_pkg::STEP_CRC_LO) begin
            crc_in = crc_fed;
            if (step_ff == mpf_pkg::STEP_SRC0) begin
               inside_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (!inside_in) begin
         step_start = mpf_pkg::STEP_SRC0;
      end else if (req_chan.payload.byte_present) begin
         step_start = mpf_pkg::STEP_PAYLOAD;
      end else begin
         step_start = mpf_pkg::STEP_CRC_LO;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      step_in       = step_ff;
      if (emit) begin
         step_in = step_next;
         if (item_done) begin
            item_valid_in = 1'b0;
         end
      end
      if (load) begin
         item_valid_in = 1'b1;
         step_in       = step_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= mpf_pkg::STEP_SRC0;
         inside_ff     <= 1'b0;
         crc_ff        <= mpf_pkg::CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         inside_ff     <= inside_in;
         crc_ff        <= crc_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_chan.payload;
      end
      if (emit) begin
         rsp_ff.frame_byte <= cur_byte;
         rsp_ff.frame_end  <= (step_ff == mpf_pkg::STEP_CRC_HI);
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // checks
   a_crc_idle_init: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> crc_ff == mpf_pkg::CRC_INIT)
      else $error("crc not at init outside a packet");

   a_close_inside: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && step_ff == mpf_pkg::STEP_CRC_HI |-> inside_ff)
      else $error("crc trailer outside a packet");

   a_payload_present: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && step_ff == mpf_pkg::STEP_PAYLOAD |-> item_ff.byte_present)
      else $error("payload step without a byte");

   a_end_after_lo: assert property (@(posedge clock) disable iff (reset)
      emit && step_ff == mpf_pkg::STEP_CRC_LO |=> item_valid_ff &&
      step_ff == mpf_pkg::STEP_CRC_HI)
      else $error("crc high byte does not follow low byte");

endmodule

// ===== hw/rtl/mpf_crc16_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_crc16_step
// One byte of reflected CRC-16 (poly 0xA001), bit-parallel.
// ----------------------------------------------------------------------------
module mpf_crc16_step (
   input  logic [mpf_pkg::CRC_W-1:0]  crc_cur,
   input  logic [mpf_pkg::BYTE_W-1:0] data_byte,
   output logic [mpf_pkg::CRC_W-1:0]  crc_nxt
);

   always_comb begin
      logic [mpf_pkg::CRC_W-1:0] c;
      c = crc_cur ^ {{(mpf_pkg::CRC_W-mpf_pkg::BYTE_W){1'b0}}, data_byte};
      for (int i = 0; i < mpf_pkg::BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mpf_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_nxt = c;
   end

endmodule

// ===== tb/sv/mesh_packet_framer_crc16_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_packet_framer_crc16_unit_tb
// Self-checking bench for the mesh packet framer. A shadow framer builds the
// header, payload and CRC-16/MODBUS trailer bytes for every item that is
// accepted. A monitor matches each output transfer against the oldest pending
// byte. Directed cases cover register extremes, empty and idle items and
// single-byte packets. Random packets follow, with bursty stalls on both
// channels, and the run ends with a section that has no stalls.
// ----------------------------------------------------------------------------
module mesh_packet_framer_crc16_unit_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [mpf_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [mpf_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [mpf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mpf_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   mpf_stream_if #(.payload_type(mpf_pkg::item_type))   req_chan ();
   mpf_stream_if #(.payload_type(mpf_pkg::result_type)) rsp_chan ();

   mesh_packet_framer_crc16_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow framer state
   logic [mpf_pkg::NODE_W-1:0] node_shadow = '0;
   logic [mpf_pkg::BYTE_W-1:0] chan_shadow = '0;
   logic                       pkt_open = 1'b0;
   logic [mpf_pkg::CRC_W-1:0]  crc_acc = mpf_pkg::CRC_INIT;
   mpf_pkg::result_type        pending_bytes[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  frames_sent = 0;
   bit  idle_on = 1'b0;
   int  stall_left = 0;

   always #4 clock = ~clock;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL mesh_packet_framer_crc16_unit");
         $finish;
      end
   end

   // sink-side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (idle_on && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 8);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      mpf_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected frame byte", int'(rsp_chan.payload.frame_byte), 0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_chan.payload.frame_byte !== want.frame_byte)
               report_mismatch("frame_byte", int'(rsp_chan.payload.frame_byte),
                               int'(want.frame_byte));
            if (rsp_chan.payload.frame_end !== want.frame_end)
               report_mismatch("frame_end", int'(rsp_chan.payload.frame_end),
                               int'(want.frame_end));
         end
      end
   end

   function automatic logic [mpf_pkg::CRC_W-1:0] crc16_update(
         input logic [mpf_pkg::CRC_W-1:0] crc, input logic [mpf_pkg::BYTE_W-1:0] b);
      logic [mpf_pkg::CRC_W-1:0] c;
      int i;
      c = crc ^ {8'h00, b};
      for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ mpf_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic push_frame_byte(input logic [mpf_pkg::BYTE_W-1:0] b, input bit crc_it,
                                  input bit is_end);
      mpf_pkg::result_type r;
      r.frame_byte = b;
      r.frame_end  = is_end;
      pending_bytes.insert(pending_bytes.size(), r);
      if (crc_it) crc_acc = crc16_update(crc_acc, b);
   endtask

   task automatic push_word(input logic [mpf_pkg::NODE_W-1:0] w);
      push_frame_byte(w[31:24], 1'b1, 1'b0);
      push_frame_byte(w[23:16], 1'b1, 1'b0);
      push_frame_byte(w[15:8],  1'b1, 1'b0);
      push_frame_byte(w[7:0],   1'b1, 1'b0);
   endtask

   task automatic frame_item(input mpf_pkg::item_type it);
      logic [mpf_pkg::CRC_W-1:0] crc;
      if (!it.byte_present && !it.last_item) return;
      frames_sent++;
      if (!pkt_open) begin
         crc_acc = mpf_pkg::CRC_INIT;
         push_word(node_shadow);
         push_word(it.dest_node);
         push_frame_byte(chan_shadow, 1'b1, 1'b0);
         pkt_open = 1'b1;
      end
      if (it.byte_present) push_frame_byte(it.payload_byte, 1'b1, 1'b0);
      if (it.last_item) begin
         crc = crc_acc;
         push_frame_byte(crc[7:0],  1'b0, 1'b0);
         push_frame_byte(crc[15:8], 1'b0, 1'b1);
         crc_acc  = mpf_pkg::CRC_INIT;
         pkt_open = 1'b0;
      end
   endtask

   function automatic mpf_pkg::item_type make_item(input logic [7:0] b, input bit present,
                                                   input bit last, input logic [31:0] dest);
      mpf_pkg::item_type it;
      it.payload_byte = b;
      it.byte_present = present;
      it.last_item    = last;
      it.dest_node    = dest;
      return it;
   endfunction

   task automatic send_item(input mpf_pkg::item_type it);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      frame_item(it);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mpf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == mpf_pkg::CSR_LOCAL_NODE) node_shadow = data;
      else if (idx == mpf_pkg::CSR_CHANNEL_NUMBER) chan_shadow = data[7:0];
   endtask

   task automatic test_reset_defaults();
      send_item(make_item(8'h5A, 1'b1, 1'b0, 32'h0102_0304));
      send_item(make_item(8'hA5, 1'b1, 1'b1, 32'hFFFF_FFFF));
      wait_for_drain();
   endtask

   task automatic test_register_extremes();
      write_csr(mpf_pkg::CSR_LOCAL_NODE, 32'hFFFF_FFFF);
      write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, 32'hFFFF_FFFF);
      send_item(make_item(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
      wait_for_drain();
      write_csr(CSR_SPARE_A, 32'h1234_5678);
      write_csr(CSR_SPARE_B, 32'h0000_0000);
      send_item(make_item(8'h00, 1'b1, 1'b1, 32'h0000_0000));
      wait_for_drain();
      write_csr(mpf_pkg::CSR_LOCAL_NODE, 32'h0000_0000);
      write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, 32'h0000_0000);
      send_item(make_item(8'h00, 1'b1, 1'b1, 32'h0000_0000));
      wait_for_drain();
      write_csr(mpf_pkg::CSR_LOCAL_NODE, 32'hDEAD_BEEF);
      write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, 32'h0000_0042);
   endtask

   task automatic test_special_items();
      // idle item with no packet open
      send_item(make_item(8'h77, 1'b0, 1'b0, 32'h1111_1111));
      // empty packet, header plus CRC
      send_item(make_item(8'h00, 1'b0, 1'b1, 32'h8000_0001));
      // idle item in the middle of a packet, then close with an empty item
      send_item(make_item(8'h01, 1'b1, 1'b0, 32'h7FFF_FFFE));
      send_item(make_item(8'h33, 1'b0, 1'b0, 32'h0000_0000));
      send_item(make_item(8'h80, 1'b1, 1'b0, 32'h5555_5555));
      send_item(make_item(8'hEE, 1'b0, 1'b1, 32'hAAAA_AAAA));
      // register write between packets applies to the next header
      wait_for_drain();
      write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, 32'h0000_0001);
      send_item(make_item(8'hC3, 1'b1, 1'b0, 32'hCAFE_F00D));
      send_item(make_item(8'h3C, 1'b1, 1'b0, 32'h0000_0000));
      send_item(make_item(8'h0F, 1'b1, 1'b1, 32'hFFFF_FFFF));
      wait_for_drain();
   endtask

   task automatic send_random_packet();
      int len;
      int i;
      bit close_empty;
      logic [31:0] dest;
      len = $urandom_range(0, 8);
      close_empty = ($urandom_range(0, 5) == 0);
      dest = $urandom;
      if (len == 0) begin
         send_item(make_item(8'($urandom), 1'b0, 1'b1, dest));
         return;
      end
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(make_item(8'($urandom), 1'b0, 1'b0, $urandom));
         send_item(make_item(8'($urandom), 1'b1, (i == len - 1) && !close_empty,
                             (i == 0) ? dest : $urandom));
      end
      if (close_empty) send_item(make_item(8'($urandom), 1'b0, 1'b1, $urandom));
   endtask

   task automatic test_random_packets(input int item_goal);
      int start;
      int pkts;
      start = frames_sent;
      pkts = 0;
      while (frames_sent - start < item_goal) begin
         send_random_packet();
         pkts++;
         if (pkts % 6 == 0) begin
            wait_for_drain();
            case ($urandom_range(0, 3))
               0: write_csr(mpf_pkg::CSR_LOCAL_NODE, $urandom);
               1: write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, $urandom);
               2: begin
                  write_csr(mpf_pkg::CSR_LOCAL_NODE, 32'hFFFF_FFFF);
                  write_csr(mpf_pkg::CSR_CHANNEL_NUMBER, 32'h0000_00FF);
               end
               default: write_csr(CSR_SPARE_B, $urandom);
            endcase
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_special_items();
      idle_on = 1'b1;
      test_random_packets(100);
      wait_for_drain();
      idle_on = 1'b0;
      test_random_packets(20);
      wait_for_drain();
      if (fail_count == 0) begin
         $display("PASS mesh_packet_framer_crc16_unit");
      end else begin
         $display("FAIL mesh_packet_framer_crc16_unit");
      end
      $finish;
   end

endmodule
